FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TCSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TCSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tcsa_pkg.sv
// ----------------------------------------------------------------------------
// tcsa_pkg
// Shared word types and codes of the transposed convolution accumulator.
// ----------------------------------------------------------------------------
package tcsa_pkg;

  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  // commands
  localparam logic [2:0] CMD_LOAD_TAP  = 3'd0;
  localparam logic [2:0] CMD_LOAD_BIAS = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_SAMPLE    = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DILATE_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DILATE_COLS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_ROWS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_COLS   = 3'd7;

  // q8.8 bias times this gives q16.16
  localparam logic signed [15:0] BIAS_SCALE = 16'sh0100;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [3:0]          chan;
    logic [6:0]          row_pos;
    logic [6:0]          col_pos;
    logic signed [15:0]  sample_value;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_value;
    logic [1:0]              status;
  } out_word_t;

endpackage

FILE: hdl/tcsa_mac.sv
// ----------------------------------------------------------------------------
// tcsa_mac
// Shared 16x16 multiplier with registered product and a saturating 48-bit add.
// ----------------------------------------------------------------------------
module tcsa_mac (
  input  logic                                  clk,
  input  logic                                  mul_en,
  input  logic signed [15:0]                    op_a,
  input  logic signed [15:0]                    op_b,
  input  logic signed [tcsa_pkg::ACC_W-1:0]     acc_in,
  output logic signed [tcsa_pkg::ACC_W-1:0]     sum
);

  localparam int AW = tcsa_pkg::ACC_W;

  logic signed [31:0] prod_r;
  logic        [AW:0] wide_c;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  // one guard bit catches overflow of the accumulate
  assign wide_c = {acc_in[AW-1], acc_in} + {{(AW-31){prod_r[31]}}, prod_r};

  always_comb begin
    if (wide_c[AW] != wide_c[AW-1]) begin
      sum = wide_c[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sum = wide_c[AW-1:0];
    end
  end

endmodule

FILE: hdl/transposed_conv2d_scatter_accumulate.sv
// ----------------------------------------------------------------------------
// transposed_conv2d_scatter_accumulate
// One output plane of a 2d transposed convolution, scatter-accumulate form.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall/in_data, one result word per input
// leaves on out_valid/out_stall/out_data. cfg_we/cfg_index/cfg_data write the
// stride, pad, dilation and kernel size registers; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// One word is worked on at a time; in_stall is high until its result has been
// moved into the output register. Tap loads, bias loads and bad words go
// straight to the output step. A read fetches the accumulator entry, passes
// the bias through the shared multiplier and adds the two. A sample takes one
// read-modify-write of the accumulator memory and one pass through the shared
// multiplier per tap landing in the plane; a tap falling off the plane is
// skipped. A clear writes every accumulator entry before its result goes out.
// The output register holds a finished word while the receiver stalls, and
// the next input word is accepted meanwhile.
// After reset the accumulator memory is cleared one entry per cycle, which
// keeps in_stall high until every entry has been written. Tap memory is not
// reset.
module transposed_conv2d_scatter_accumulate #(
  parameter int CHANNELS  = 16,
  parameter int KMAX      = 7,
  parameter int PLANE_DIM = 128,
  parameter int IN_DIM    = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  tcsa_pkg::in_word_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output tcsa_pkg::out_word_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [tcsa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tcsa_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int TAP_DEPTH = CHANNELS * KMAX * KMAX;
  localparam int TAW       = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int ACC_DEPTH = PLANE_DIM * PLANE_DIM;
  localparam int AW        = $clog2(ACC_DEPTH);
  localparam int PW        = $clog2(PLANE_DIM);
  localparam int KW        = $clog2(KMAX + 1);
  localparam int CW0       = (10 > KW + 2) ? 11 : KW + 3;
  localparam int CW        = (CW0 > PW + 1) ? CW0 : PW + 1;
  localparam int ACC_W     = tcsa_pkg::ACC_W;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_TAP   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_WR    = 9'b000010000,
    S_RDMUL = 9'b000100000,
    S_RDADD = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [KW-1:0]           tr_r, tr_nxt, tc_r, tc_nxt;
  logic                    drop_r, drop_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic                    clr_resp_r, clr_resp_nxt;
  logic [AW-1:0]           acc_addr_r, acc_addr_nxt;
  logic signed [ACC_W-1:0] res_acc_r, res_acc_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  tcsa_pkg::out_word_t     out_data_r, out_data_nxt;
  tcsa_pkg::in_word_t      item_r;
  logic signed [15:0]      bias_r;

  logic [2:0] stride_rows_r, stride_cols_r, pad_rows_r, pad_cols_r;
  logic [1:0] dilate_rows_r, dilate_cols_r;
  logic [2:0] taps_rows_r, taps_cols_r;

  // memories
  logic signed [15:0]      tap_mem [TAP_DEPTH];
  logic signed [ACC_W-1:0] acc_mem [ACC_DEPTH];
  logic signed [15:0]      tap_rd_r;
  logic signed [ACC_W-1:0] acc_rd_r;

  logic                    accept_c;
  logic                    tap_we, tap_re, acc_we, acc_re, mul_en;
  logic [TAW-1:0]          tap_wa_c, tap_ra_c;
  logic [AW-1:0]           acc_wa, acc_ra, rd_addr_c, pos_addr_c;
  logic signed [ACC_W-1:0] acc_wd, mac_sum;
  logic signed [15:0]      op_a, op_b;
  logic                    tap_ok_c, smp_ok_c, rd_ok_c, pos_ok_c;
  logic [KW-1:0]           nr_c, nc_c;
  logic                    tc_last_c, last_c;
  logic [CW-1:0]           pr_c, pc_c, rr_c, rc_c;

  assign accept_c = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // kernel size clamped to the stored kernel
  assign nr_c = (32'(taps_rows_r) > KMAX) ? KW'(KMAX) : KW'(taps_rows_r);
  assign nc_c = (32'(taps_cols_r) > KMAX) ? KW'(KMAX) : KW'(taps_cols_r);

  assign tap_ok_c = (32'(in_data.chan) < CHANNELS) && (32'(in_data.row_pos) < KMAX) &&
                    (32'(in_data.col_pos) < KMAX);
  assign smp_ok_c = (32'(in_data.chan) < CHANNELS) && (32'(in_data.row_pos) < IN_DIM) &&
                    (32'(in_data.col_pos) < IN_DIM);

  assign tap_wa_c = TAW'(in_data.chan) * TAW'(KMAX * KMAX) +
                    TAW'(in_data.row_pos) * TAW'(KMAX) + TAW'(in_data.col_pos);
  assign tap_ra_c = TAW'(item_r.chan) * TAW'(KMAX * KMAX) +
                    TAW'(tr_r) * TAW'(KMAX) + TAW'(tc_r);

  // read position with padding offset
  assign rr_c      = CW'(in_data.row_pos) + CW'(pad_rows_r);
  assign rc_c      = CW'(in_data.col_pos) + CW'(pad_cols_r);
  assign rd_ok_c   = (rr_c < CW'(PLANE_DIM)) && (rc_c < CW'(PLANE_DIM));
  assign rd_addr_c = AW'(rr_c[PW-1:0]) * AW'(PLANE_DIM) + AW'(rc_c[PW-1:0]);

  // scatter position of the current tap
  assign pr_c = CW'(item_r.row_pos) * CW'(stride_rows_r) + CW'(tr_r) * CW'(dilate_rows_r);
  assign pc_c = CW'(item_r.col_pos) * CW'(stride_cols_r) + CW'(tc_r) * CW'(dilate_cols_r);
  assign pos_ok_c   = (pr_c < CW'(PLANE_DIM)) && (pc_c < CW'(PLANE_DIM));
  assign pos_addr_c = AW'(pr_c[PW-1:0]) * AW'(PLANE_DIM) + AW'(pc_c[PW-1:0]);

  assign tc_last_c = (tc_r == KW'(nc_c - 1'b1));
  assign last_c    = tc_last_c && (tr_r == KW'(nr_c - 1'b1));

  tcsa_mac u_mac (
    .clk    (clk),
    .mul_en (mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .acc_in (acc_rd_r),
    .sum    (mac_sum)
  );

  always_comb begin
    state_nxt      = state_r;
    tr_nxt         = tr_r;
    tc_nxt         = tc_r;
    drop_nxt       = drop_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_resp_nxt   = clr_resp_r;
    acc_addr_nxt   = acc_addr_r;
    res_acc_nxt    = res_acc_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    tap_we         = 1'b0;
    tap_re         = 1'b0;
    acc_we         = 1'b0;
    acc_re         = 1'b0;
    acc_wa         = clr_cnt_r;
    acc_wd         = '0;
    acc_ra         = rd_addr_c;
    mul_en         = 1'b0;
    op_a           = item_r.sample_value;
    op_b           = tap_rd_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        acc_we = 1'b1;
        if (clr_cnt_r == AW'(ACC_DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_resp_r ? S_DONE : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_acc_nxt    = '0;
          res_status_nxt = tcsa_pkg::ST_OK;
          tr_nxt         = '0;
          tc_nxt         = '0;
          drop_nxt       = 1'b0;
          state_nxt      = S_DONE;
          case (in_data.cmd)
            tcsa_pkg::CMD_LOAD_TAP: begin
              if (tap_ok_c) begin
                tap_we = 1'b1;
              end else begin
                res_status_nxt = tcsa_pkg::ST_BAD;
              end
            end
            tcsa_pkg::CMD_LOAD_BIAS: begin
              state_nxt = S_DONE;
            end
            tcsa_pkg::CMD_CLEAR: begin
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            tcsa_pkg::CMD_SAMPLE: begin
              if (!smp_ok_c) begin
                res_status_nxt = tcsa_pkg::ST_BAD;
              end else if (nr_c != '0 && nc_c != '0) begin
                state_nxt = S_TAP;
              end
            end
            tcsa_pkg::CMD_READ: begin
              if (rd_ok_c) begin
                acc_re    = 1'b1;
                state_nxt = S_RDMUL;
              end else begin
                res_status_nxt = tcsa_pkg::ST_BAD;
              end
            end
            default: begin
              res_status_nxt = tcsa_pkg::ST_BAD;
            end
          endcase
        end
      end
      S_TAP: begin
        if (pos_ok_c) begin
          acc_re       = 1'b1;
          acc_ra       = pos_addr_c;
          tap_re       = 1'b1;
          acc_addr_nxt = pos_addr_c;
          state_nxt    = S_MUL;
        end else begin
          // tap lands off the plane: skip it
          drop_nxt = 1'b1;
          tc_nxt   = tc_last_c ? '0 : KW'(tc_r + 1'b1);
          tr_nxt   = tc_last_c ? KW'(tr_r + 1'b1) : tr_r;
          if (last_c) begin
            res_status_nxt = tcsa_pkg::ST_DROP;
            state_nxt      = S_DONE;
          end
        end
      end
      S_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        acc_we = 1'b1;
        acc_wa = acc_addr_r;
        acc_wd = mac_sum;
        tc_nxt = tc_last_c ? '0 : KW'(tc_r + 1'b1);
        tr_nxt = tc_last_c ? KW'(tr_r + 1'b1) : tr_r;
        if (last_c) begin
          res_status_nxt = drop_r ? tcsa_pkg::ST_DROP : tcsa_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_TAP;
        end
      end
      S_RDMUL: begin
        mul_en    = 1'b1;
        op_a      = bias_r;
        op_b      = tcsa_pkg::BIAS_SCALE;
        state_nxt = S_RDADD;
      end
      S_RDADD: begin
        res_acc_nxt = mac_sum;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.acc_value = res_acc_r;
          out_data_nxt.status    = res_status_r;
          clr_resp_nxt           = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      tr_r        <= '0;
      tc_r        <= '0;
      drop_r      <= 1'b0;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bias_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      tr_r        <= tr_nxt;
      tc_r        <= tc_nxt;
      drop_r      <= drop_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept_c && in_data.cmd == tcsa_pkg::CMD_LOAD_BIAS) begin
        bias_r <= in_data.sample_value;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_addr_r   <= acc_addr_nxt;
    res_acc_r    <= res_acc_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    if (accept_c) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_rows_r <= 3'd1;
      stride_cols_r <= 3'd1;
      pad_rows_r    <= 3'd0;
      pad_cols_r    <= 3'd0;
      dilate_rows_r <= 2'd1;
      dilate_cols_r <= 2'd1;
      taps_rows_r   <= 3'd3;
      taps_cols_r   <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        tcsa_pkg::REG_STRIDE_ROWS: stride_rows_r <= cfg_data;
        tcsa_pkg::REG_STRIDE_COLS: stride_cols_r <= cfg_data;
        tcsa_pkg::REG_PAD_ROWS:    pad_rows_r    <= cfg_data;
        tcsa_pkg::REG_PAD_COLS:    pad_cols_r    <= cfg_data;
        tcsa_pkg::REG_DILATE_ROWS: dilate_rows_r <= cfg_data[1:0];
        tcsa_pkg::REG_DILATE_COLS: dilate_cols_r <= cfg_data[1:0];
        tcsa_pkg::REG_TAPS_ROWS:   taps_rows_r   <= cfg_data;
        tcsa_pkg::REG_TAPS_COLS:   taps_cols_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_wa_c] <= in_data.sample_value;
    end
    if (tap_re) begin
      tap_rd_r <= tap_mem[tap_ra_c];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_r <= acc_mem[acc_ra];
    end
  end

endmodule

FILE: hdl/tcsa_checker.sv
// ----------------------------------------------------------------------------
// tcsa_checker
// Port-level checks of the transposed convolution accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcsa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tcsa_pkg::out_word_t out_data
);

  logic in_acc, st_ok, st_drop, st_bad;

  assign in_acc  = in_valid && !in_stall;
  assign st_ok   = (out_data.status == tcsa_pkg::ST_OK);
  assign st_drop = (out_data.status == tcsa_pkg::ST_DROP);
  assign st_bad  = (out_data.status == tcsa_pkg::ST_BAD);

  // one word at a time: busy right after an accept
  `TCSA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall, "accept while busy")

  // accumulator clearing pass runs right after reset
  `TCSA_ASSERT_IMP(a_clear_after_reset, clk, rst_n, $past(!rst_n), in_stall, "no clear pass")

  // a word without ok status carries a zero value; only reads carry one
  `TCSA_ASSERT_IMP(a_zero_unless_ok, clk, rst_n, out_valid && !st_ok, out_data.acc_value == '0, "value on failed word")

  `TCSA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, st_ok || st_drop || st_bad, "bad status code")

  `TCSA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result word dropped")

endmodule

bind transposed_conv2d_scatter_accumulate tcsa_checker u_tcsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/tb_transposed_conv2d_scatter_accumulate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transposed_conv2d_scatter_accumulate
// Self-checking bench for the transposed convolution scatter-accumulate plane.
// A queue of words feeds a valid/stall driver, and each accepted word is run
// through a local model of the tap memory, bias and accumulator plane. The
// monitor compares every result word with the oldest prediction. A directed
// set of corner words comes first, then random phases under several register
// settings, with random idling on both channels and one phase without it.
// ----------------------------------------------------------------------------
module tb_transposed_conv2d_scatter_accumulate;
  import tcsa_pkg::*;

  localparam int KMAX        = 7;
  localparam int PLANE       = 128;
  localparam int IN_DIM      = 32;
  localparam int CHANNELS    = 16;
  localparam int QUIET_LIMIT = 100000;
  localparam int PHASE_WORDS = 80;

  localparam logic [2:0] CMD_FIRST_UNUSED = CMD_READ + 3'd1;
  localparam logic [2:0] CMD_LAST_UNUSED  = '1;

  localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies used by both stimulus and prediction
  logic [2:0] stride_r = 3'd1, stride_c = 3'd1;
  logic [2:0] pad_r = 3'd0, pad_c = 3'd0;
  logic [1:0] dil_r = 2'd1, dil_c = 2'd1;
  logic [2:0] taps_r = 3'd3, taps_c = 3'd3;

  logic signed [15:0]      tap_mem [CHANNELS*KMAX*KMAX];
  bit                      tap_known [CHANNELS*KMAX*KMAX];
  logic signed [15:0]      bias_q = '0;
  logic signed [ACC_W-1:0] acc_mem [PLANE*PLANE];

  in_word_t  pending_words [$];
  out_word_t owed_results [$];
  out_word_t oldest;

  bit no_idle = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;
  int words_accepted = 0;
  int settings_used = 0;
  int cnt_samples = 0, cnt_dropping = 0, cnt_reads = 0, cnt_clears = 0, cnt_rejected = 0;

  transposed_conv2d_scatter_accumulate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int tap_slot(logic [3:0] chan, logic [6:0] row, logic [6:0] col);
    return (int'(chan) * KMAX + int'(row)) * KMAX + int'(col);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(longint s);
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s[ACC_W-1:0];
  endfunction

  function automatic void clear_plane();
    for (int i = 0; i < PLANE*PLANE; i++) acc_mem[i] = '0;
  endfunction

  // result of one word, with its effect on taps, bias and plane
  function automatic out_word_t scatter_result(in_word_t w);
    out_word_t res;
    int nr, nc, pr, pc, slot;
    longint sample, weight, held;
    res.acc_value = '0;
    res.status = ST_OK;
    sample = w.sample_value;
    case (w.cmd)
      CMD_LOAD_TAP: begin
        if (w.row_pos < KMAX && w.col_pos < KMAX)
          tap_mem[tap_slot(w.chan, w.row_pos, w.col_pos)] = w.sample_value;
        else
          res.status = ST_BAD;
      end
      CMD_LOAD_BIAS: bias_q = w.sample_value;
      CMD_CLEAR: begin
        clear_plane();
        cnt_clears++;
      end
      CMD_SAMPLE: begin
        if (w.row_pos < IN_DIM && w.col_pos < IN_DIM) begin
          nr = (taps_r > KMAX) ? KMAX : int'(taps_r);
          nc = (taps_c > KMAX) ? KMAX : int'(taps_c);
          for (int tr = 0; tr < nr; tr++) begin
            pr = int'(w.row_pos) * int'(stride_r) + tr * int'(dil_r);
            for (int tc = 0; tc < nc; tc++) begin
              pc = int'(w.col_pos) * int'(stride_c) + tc * int'(dil_c);
              if (pr >= PLANE || pc >= PLANE) begin
                res.status = ST_DROP;
              end else begin
                weight = tap_mem[tap_slot(w.chan, tr[6:0], tc[6:0])];
                slot = pr * PLANE + pc;
                held = acc_mem[slot];
                acc_mem[slot] = sat48(held + sample * weight);
              end
            end
          end
          cnt_samples++;
          if (res.status == ST_DROP) cnt_dropping++;
        end else begin
          res.status = ST_BAD;
        end
      end
      CMD_READ: begin
        pr = int'(w.row_pos) + int'(pad_r);
        pc = int'(w.col_pos) + int'(pad_c);
        if (pr < PLANE && pc < PLANE) begin
          held = acc_mem[pr * PLANE + pc];
          weight = bias_q;
          res.acc_value = sat48(held + weight * 256);
          cnt_reads++;
        end else begin
          res.status = ST_BAD;
        end
      end
      default: res.status = ST_BAD;
    endcase
    if (res.status == ST_BAD) cnt_rejected++;
    return res;
  endfunction

  // queues a word; a good sample first gets loads for any tap it would use unwritten
  function automatic void send_word(logic [2:0] cmd, logic [3:0] chan, logic [6:0] row,
                                    logic [6:0] col, logic [15:0] value);
    in_word_t w;
    int nr, nc;
    if (cmd == CMD_SAMPLE && row < IN_DIM && col < IN_DIM) begin
      nr = (taps_r > KMAX) ? KMAX : int'(taps_r);
      nc = (taps_c > KMAX) ? KMAX : int'(taps_c);
      for (int tr = 0; tr < nr; tr++) begin
        for (int tc = 0; tc < nc; tc++) begin
          if (!tap_known[tap_slot(chan, tr[6:0], tc[6:0])]) begin
            w.cmd = CMD_LOAD_TAP;
            w.chan = chan;
            w.row_pos = tr[6:0];
            w.col_pos = tc[6:0];
            w.sample_value = $urandom;
            pending_words.push_back(w);
            tap_known[tap_slot(chan, tr[6:0], tc[6:0])] = 1'b1;
          end
        end
      end
    end
    if (cmd == CMD_LOAD_TAP && row < KMAX && col < KMAX)
      tap_known[tap_slot(chan, row, col)] = 1'b1;
    w.cmd = cmd;
    w.chan = chan;
    w.row_pos = row;
    w.col_pos = col;
    w.sample_value = value;
    pending_words.push_back(w);
  endfunction

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void random_word();
    int r;
    logic [3:0] ch;
    logic [6:0] row, col;
    r = $urandom_range(99);
    // mostly a few channels, so few tap loads are needed ahead of samples
    ch = ($urandom_range(19) != 0) ? $urandom_range(3) : $urandom_range(CHANNELS-1);
    if (r == 0) begin
      send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (r <= 42) begin
      if ($urandom_range(99) < 92) begin
        row = $urandom_range(IN_DIM-1);
        col = $urandom_range(IN_DIM-1);
      end else if ($urandom_range(1)) begin
        row = $urandom_range(PLANE-1, IN_DIM);
        col = $urandom;
      end else begin
        row = $urandom;
        col = $urandom_range(PLANE-1, IN_DIM);
      end
      send_word(CMD_SAMPLE, ch, row, col, rand_q88());
    end else if (r <= 72) begin
      row = ($urandom_range(3) != 0) ? $urandom_range(40) : $urandom_range(PLANE-1);
      col = ($urandom_range(3) != 0) ? $urandom_range(40) : $urandom_range(PLANE-1);
      send_word(CMD_READ, $urandom, row, col, $urandom);
    end else if (r <= 84) begin
      if ($urandom_range(99) < 85) begin
        row = $urandom_range(KMAX-1);
        col = $urandom_range(KMAX-1);
      end else begin
        row = $urandom;
        col = $urandom;
      end
      send_word(CMD_LOAD_TAP, $urandom, row, col, rand_q88());
    end else if (r <= 90) begin
      send_word(CMD_LOAD_BIAS, $urandom, $urandom, $urandom, rand_q88());
    end else if (r <= 94) begin
      send_word($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED), $urandom, $urandom,
                $urandom, $urandom);
    end else begin
      send_word($urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [2:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_STRIDE_ROWS: stride_r = val;
      REG_STRIDE_COLS: stride_c = val;
      REG_PAD_ROWS:    pad_r = val;
      REG_PAD_COLS:    pad_c = val;
      REG_DILATE_ROWS: dil_r = val[1:0];
      REG_DILATE_COLS: dil_c = val[1:0];
      REG_TAPS_ROWS:   taps_r = val;
      REG_TAPS_COLS:   taps_c = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [2:0] sr, logic [2:0] sc, logic [2:0] pr,
                                logic [2:0] pc, logic [2:0] dr, logic [2:0] dc,
                                logic [2:0] tr, logic [2:0] tc);
    write_reg(REG_STRIDE_ROWS, sr);
    write_reg(REG_STRIDE_COLS, sc);
    write_reg(REG_PAD_ROWS, pr);
    write_reg(REG_PAD_COLS, pc);
    write_reg(REG_DILATE_ROWS, dr);
    write_reg(REG_DILATE_COLS, dc);
    write_reg(REG_TAPS_ROWS, tr);
    write_reg(REG_TAPS_COLS, tc);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // every queued word sent and every result back, then a short settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic flag_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_results.push_back(scatter_result(in_data));
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 26)) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("result word with none owed: acc %0d status %0d",
                                  out_data.acc_value, out_data.status));
        end else begin
          oldest = owed_results.pop_front();
          if (out_data.acc_value !== oldest.acc_value)
            flag_mismatch($sformatf("acc_value got %0d want %0d",
                                    out_data.acc_value, oldest.acc_value));
          if (out_data.status !== oldest.status)
            flag_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, oldest.status));
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 26);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_plane();
    for (int i = 0; i < CHANNELS*KMAX*KMAX; i++) begin
      tap_mem[i] = '0;
      tap_known[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // block clears its plane after reset
    repeat (3) @(negedge clk);
    while (in_stall) @(negedge clk);

    // corner words: wide stride and dilation so the bottom edge drops taps
    apply_settings(3'd4, 3'd4, 3'd7, 3'd7, 3'd2, 3'd2, 3'd3, 3'd1);
    send_word(CMD_READ, 4'd0, 7'd0, 7'd0, 16'h0000);
    send_word(CMD_LOAD_BIAS, 4'd0, 7'd0, 7'd0, 16'h7FFF);
    send_word(CMD_LOAD_TAP, 4'd0, 7'd0, 7'd0, 16'h7FFF);
    send_word(CMD_LOAD_TAP, 4'd0, 7'd1, 7'd0, 16'h8000);
    send_word(CMD_LOAD_TAP, 4'd0, 7'd2, 7'd0, 16'h0100);
    send_word(CMD_SAMPLE, 4'd0, 7'd31, 7'd31, 16'h8000);
    send_word(CMD_SAMPLE, 4'd0, 7'd2, 7'd2, 16'h7FFF);
    send_word(CMD_READ, 4'd0, 7'd1, 7'd1, 16'h0000);
    send_word(CMD_READ, 4'd0, 7'd3, 7'd1, 16'h0000);
    send_word(CMD_READ, 4'd15, 7'd120, 7'd120, 16'hFFFF);
    send_word(CMD_READ, 4'd0, 7'd121, 7'd0, 16'h0000);
    send_word(CMD_READ, 4'd0, 7'd0, 7'd127, 16'h0000);
    send_word(CMD_LOAD_TAP, 4'd15, 7'd6, 7'd6, 16'hFFFF);
    send_word(CMD_LOAD_TAP, 4'd15, 7'd7, 7'd0, 16'h1234);
    send_word(CMD_LOAD_TAP, 4'd3, 7'd0, 7'd127, 16'h1234);
    send_word(CMD_LOAD_BIAS, 4'd0, 7'd0, 7'd0, 16'h8000);
    send_word(CMD_READ, 4'd0, 7'd1, 7'd1, 16'h0000);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
      send_word(c[2:0], $urandom, $urandom, $urandom, $urandom);
    send_word(CMD_SAMPLE, 4'd15, 7'd32, 7'd0, 16'h0100);
    send_word(CMD_SAMPLE, 4'd7, 7'd0, 7'd127, 16'h0100);
    send_word(CMD_CLEAR, 4'd0, 7'd0, 7'd0, 16'h0000);
    send_word(CMD_READ, 4'd0, 7'd1, 7'd1, 16'h0000);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      no_idle = (ph == 2);
      case (ph)
        0: apply_settings(3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1);
        1: apply_settings(3'd4, 3'd4, 3'd7, 3'd7, 3'd2, 3'd2, 3'd7, 3'd7);
        2: apply_settings(3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd3, 3'd3);
        default: apply_settings($urandom_range(4, 1), $urandom_range(4, 1),
                                $urandom_range(7), $urandom_range(7),
                                $urandom_range(2, 1), $urandom_range(2, 1),
                                $urandom_range(7, 1), $urandom_range(7, 1));
      endcase
      repeat (PHASE_WORDS) random_word();
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (20) @(posedge clk);
    $display("covered %0d words under %0d register settings: %0d samples (%0d dropping taps)",
             words_accepted, settings_used, cnt_samples, cnt_dropping);
    $display("  %0d reads, %0d plane clears, %0d words rejected, %0d mismatches",
             cnt_reads, cnt_clears, cnt_rejected, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
